>>> src/csq_pkg.sv
// Shared constants, types and pattern tables of the chord pattern sequencer.
package csq_pkg;

  localparam int MAX_HELD     = 16;
  localparam int MAX_SOUNDING = 32;
  localparam int SLOT_COUNT   = 12;
  localparam int RES_MAX      = 64;

  localparam int HELD_IW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
  localparam int HELD_CW = $clog2(MAX_HELD + 1);
  localparam int SND_IW  = $clog2(MAX_SOUNDING);
  localparam int SND_CW  = $clog2(MAX_SOUNDING + 1);
  localparam int RES_CW  = $clog2(RES_MAX + 1);
  localparam int GEN_CW  = $clog2(SLOT_COUNT + MAX_HELD);
  localparam int SLOT_IW = $clog2(SLOT_COUNT);
  localparam int VAL_W   = 9;
  localparam int ROM_IW  = 7;

  localparam logic [10:0] BAR_LEN = 11'd1920;

  localparam logic [1:0] ACT_ON   = 2'd0;
  localparam logic [1:0] ACT_OFF  = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [1:0] PAT_PIANO  = 2'd0;
  localparam logic [1:0] PAT_GUITAR = 2'd1;
  localparam logic [1:0] PAT_SYNTH  = 2'd2;

  localparam logic KIND_ON  = 1'b0;
  localparam logic KIND_OFF = 1'b1;

  typedef enum logic [1:0] {EV_PASS, EV_HELD_ON, EV_HELD_OFF, EV_TICK} ev_t;

  typedef struct packed {
    ev_t         ev;
    logic        act_off;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [3:0]  ch;
    logic [10:0] now;
    logic        full;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] note;
    logic [6:0] vel;
    logic [3:0] ch;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [10:0] t;
    logic        off;
    logic [6:0]  d1;
    logic [6:0]  d2;
  } rom_item_t;

  localparam logic N_ = KIND_ON;
  localparam logic F_ = KIND_OFF;

  function automatic logic [ROM_IW-1:0] rom_len(input logic [1:0] psel);
    logic [ROM_IW-1:0] r;
    case (psel)
      PAT_PIANO:  r = 7'd16;
      PAT_GUITAR: r = 7'd79;
      PAT_SYNTH:  r = 7'd60;
      default:    r = 7'd0;
    endcase
    return r;
  endfunction

  function automatic rom_item_t rom_piano(input logic [ROM_IW-1:0] i);
    rom_item_t r;
    case (i)
      7'd0:  r = {11'd0, N_, 7'h3C, 7'h6B};     7'd1:  r = {11'd240, N_, 7'h3D, 7'h5C};
      7'd2:  r = {11'd480, N_, 7'h3E, 7'h64};   7'd3:  r = {11'd720, F_, 7'h3C, 7'h40};
      7'd4:  r = {11'd720, N_, 7'h3C, 7'h50};   7'd5:  r = {11'd960, N_, 7'h3F, 7'h6F};
      7'd6:  r = {11'd1200, F_, 7'h3E, 7'h40};  7'd7:  r = {11'd1200, N_, 7'h3E, 7'h64};
      7'd8:  r = {11'd1440, F_, 7'h3D, 7'h40};  7'd9:  r = {11'd1440, N_, 7'h3D, 7'h52};
      7'd10: r = {11'd1680, F_, 7'h3C, 7'h40};  7'd11: r = {11'd1680, N_, 7'h3C, 7'h4B};
      7'd12: r = {11'd1920, F_, 7'h3F, 7'h40};  7'd13: r = {11'd1920, F_, 7'h3E, 7'h40};
      7'd14: r = {11'd1920, F_, 7'h3D, 7'h40};  7'd15: r = {11'd1920, F_, 7'h3C, 7'h40};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic rom_item_t rom_guitar(input logic [ROM_IW-1:0] i);
    rom_item_t r;
    case (i)
      7'd0:  r = {11'd0, N_, 7'h30, 7'h69};     7'd1:  r = {11'd0, N_, 7'h32, 7'h5D};
      7'd2:  r = {11'd0, N_, 7'h3C, 7'h69};     7'd3:  r = {11'd0, N_, 7'h3D, 7'h69};
      7'd4:  r = {11'd0, N_, 7'h3E, 7'h69};     7'd5:  r = {11'd0, N_, 7'h3F, 7'h69};
      7'd6:  r = {11'd240, N_, 7'h32, 7'h1B};   7'd7:  r = {11'd240, N_, 7'h3C, 7'h17};
      7'd8:  r = {11'd240, N_, 7'h3D, 7'h27};   7'd9:  r = {11'd240, N_, 7'h3E, 7'h22};
      7'd10: r = {11'd240, N_, 7'h3F, 7'h27};   7'd11: r = {11'd480, N_, 7'h30, 7'h51};
      7'd12: r = {11'd480, N_, 7'h32, 7'h45};   7'd13: r = {11'd480, N_, 7'h3C, 7'h43};
      7'd14: r = {11'd480, N_, 7'h3D, 7'h43};   7'd15: r = {11'd480, N_, 7'h3E, 7'h43};
      7'd16: r = {11'd480, N_, 7'h3F, 7'h43};   7'd17: r = {11'd720, F_, 7'h30, 7'h40};
      7'd18: r = {11'd720, F_, 7'h32, 7'h40};   7'd19: r = {11'd720, F_, 7'h3C, 7'h40};
      7'd20: r = {11'd720, F_, 7'h3D, 7'h40};   7'd21: r = {11'd720, F_, 7'h3E, 7'h40};
      7'd22: r = {11'd720, F_, 7'h3F, 7'h40};   7'd23: r = {11'd720, N_, 7'h3C, 7'h32};
      7'd24: r = {11'd720, N_, 7'h3D, 7'h32};   7'd25: r = {11'd720, N_, 7'h3E, 7'h32};
      7'd26: r = {11'd720, N_, 7'h3F, 7'h32};   7'd27: r = {11'd780, F_, 7'h3C, 7'h40};
      7'd28: r = {11'd780, F_, 7'h3D, 7'h40};   7'd29: r = {11'd780, F_, 7'h3E, 7'h40};
      7'd30: r = {11'd780, F_, 7'h3F, 7'h40};   7'd31: r = {11'd840, N_, 7'h30, 7'h6D};
      7'd32: r = {11'd840, N_, 7'h32, 7'h61};   7'd33: r = {11'd840, N_, 7'h3C, 7'h6D};
      7'd34: r = {11'd840, N_, 7'h3D, 7'h6D};   7'd35: r = {11'd840, N_, 7'h3E, 7'h6D};
      7'd36: r = {11'd840, N_, 7'h3F, 7'h6D};   7'd37: r = {11'd1080, N_, 7'h3C, 7'h47};
      7'd38: r = {11'd1080, N_, 7'h3D, 7'h47};  7'd39: r = {11'd1080, N_, 7'h3E, 7'h47};
      7'd40: r = {11'd1080, N_, 7'h3F, 7'h47};  7'd41: r = {11'd1200, N_, 7'h30, 7'h30};
      7'd42: r = {11'd1200, N_, 7'h32, 7'h24};  7'd43: r = {11'd1200, N_, 7'h3C, 7'h30};
      7'd44: r = {11'd1200, N_, 7'h3D, 7'h30};  7'd45: r = {11'd1200, N_, 7'h3E, 7'h30};
      7'd46: r = {11'd1200, N_, 7'h3F, 7'h30};  7'd47: r = {11'd1440, N_, 7'h30, 7'h51};
      7'd48: r = {11'd1440, N_, 7'h32, 7'h45};  7'd49: r = {11'd1440, N_, 7'h3C, 7'h51};
      7'd50: r = {11'd1440, N_, 7'h3D, 7'h51};  7'd51: r = {11'd1440, N_, 7'h3E, 7'h51};
      7'd52: r = {11'd1440, N_, 7'h3F, 7'h51};  7'd53: r = {11'd1680, F_, 7'h30, 7'h40};
      7'd54: r = {11'd1680, F_, 7'h32, 7'h40};  7'd55: r = {11'd1680, F_, 7'h3C, 7'h40};
      7'd56: r = {11'd1680, F_, 7'h3D, 7'h40};  7'd57: r = {11'd1680, F_, 7'h3E, 7'h40};
      7'd58: r = {11'd1680, F_, 7'h3F, 7'h40};  7'd59: r = {11'd1680, N_, 7'h30, 7'h2A};
      7'd60: r = {11'd1680, N_, 7'h32, 7'h1E};  7'd61: r = {11'd1680, N_, 7'h3C, 7'h1F};
      7'd62: r = {11'd1680, N_, 7'h3D, 7'h1F};  7'd63: r = {11'd1680, N_, 7'h3E, 7'h1F};
      7'd64: r = {11'd1680, N_, 7'h3F, 7'h1F};  7'd65: r = {11'd1740, F_, 7'h30, 7'h40};
      7'd66: r = {11'd1740, F_, 7'h32, 7'h40};  7'd67: r = {11'd1740, F_, 7'h3C, 7'h40};
      7'd68: r = {11'd1740, F_, 7'h3D, 7'h40};  7'd69: r = {11'd1740, F_, 7'h3E, 7'h40};
      7'd70: r = {11'd1740, F_, 7'h3F, 7'h40};  7'd71: r = {11'd1800, N_, 7'h3C, 7'h3A};
      7'd72: r = {11'd1800, N_, 7'h3D, 7'h3A};  7'd73: r = {11'd1800, N_, 7'h3E, 7'h3A};
      7'd74: r = {11'd1800, N_, 7'h3F, 7'h3A};  7'd75: r = {11'd1920, F_, 7'h3C, 7'h40};
      7'd76: r = {11'd1920, F_, 7'h3D, 7'h40};  7'd77: r = {11'd1920, F_, 7'h3E, 7'h40};
      7'd78: r = {11'd1920, F_, 7'h3F, 7'h40};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic rom_item_t rom_synth(input logic [ROM_IW-1:0] i);
    rom_item_t r;
    case (i)
      7'd0:  r = {11'd0, N_, 7'h30, 7'h41};     7'd1:  r = {11'd0, N_, 7'h32, 7'h41};
      7'd2:  r = {11'd0, N_, 7'h3C, 7'h74};     7'd3:  r = {11'd0, N_, 7'h3D, 7'h74};
      7'd4:  r = {11'd0, N_, 7'h3E, 7'h74};     7'd5:  r = {11'd0, N_, 7'h3F, 7'h74};
      7'd6:  r = {11'd360, F_, 7'h30, 7'h40};   7'd7:  r = {11'd360, F_, 7'h32, 7'h40};
      7'd8:  r = {11'd360, F_, 7'h3C, 7'h40};   7'd9:  r = {11'd360, F_, 7'h3D, 7'h40};
      7'd10: r = {11'd360, F_, 7'h3E, 7'h40};   7'd11: r = {11'd360, F_, 7'h3F, 7'h40};
      7'd12: r = {11'd360, N_, 7'h30, 7'h41};   7'd13: r = {11'd360, N_, 7'h32, 7'h41};
      7'd14: r = {11'd360, N_, 7'h3C, 7'h74};   7'd15: r = {11'd360, N_, 7'h3D, 7'h74};
      7'd16: r = {11'd360, N_, 7'h3E, 7'h74};   7'd17: r = {11'd360, N_, 7'h3F, 7'h74};
      7'd18: r = {11'd480, F_, 7'h30, 7'h40};   7'd19: r = {11'd480, F_, 7'h32, 7'h40};
      7'd20: r = {11'd480, F_, 7'h3C, 7'h40};   7'd21: r = {11'd480, F_, 7'h3D, 7'h40};
      7'd22: r = {11'd480, F_, 7'h3E, 7'h40};   7'd23: r = {11'd480, F_, 7'h3F, 7'h40};
      7'd24: r = {11'd720, N_, 7'h30, 7'h41};   7'd25: r = {11'd720, N_, 7'h32, 7'h41};
      7'd26: r = {11'd720, N_, 7'h3C, 7'h74};   7'd27: r = {11'd720, N_, 7'h3D, 7'h74};
      7'd28: r = {11'd720, N_, 7'h3E, 7'h74};   7'd29: r = {11'd720, N_, 7'h3F, 7'h74};
      7'd30: r = {11'd960, F_, 7'h30, 7'h40};   7'd31: r = {11'd960, F_, 7'h32, 7'h40};
      7'd32: r = {11'd960, F_, 7'h3C, 7'h40};   7'd33: r = {11'd960, F_, 7'h3D, 7'h40};
      7'd34: r = {11'd960, F_, 7'h3E, 7'h40};   7'd35: r = {11'd960, F_, 7'h3F, 7'h40};
      7'd36: r = {11'd1200, N_, 7'h30, 7'h41};  7'd37: r = {11'd1200, N_, 7'h32, 7'h41};
      7'd38: r = {11'd1200, N_, 7'h3C, 7'h74};  7'd39: r = {11'd1200, N_, 7'h3D, 7'h74};
      7'd40: r = {11'd1200, N_, 7'h3E, 7'h74};  7'd41: r = {11'd1200, N_, 7'h3F, 7'h74};
      7'd42: r = {11'd1560, F_, 7'h30, 7'h40};  7'd43: r = {11'd1560, F_, 7'h32, 7'h40};
      7'd44: r = {11'd1560, F_, 7'h3C, 7'h40};  7'd45: r = {11'd1560, F_, 7'h3D, 7'h40};
      7'd46: r = {11'd1560, F_, 7'h3E, 7'h40};  7'd47: r = {11'd1560, F_, 7'h3F, 7'h40};
      7'd48: r = {11'd1560, N_, 7'h30, 7'h41};  7'd49: r = {11'd1560, N_, 7'h32, 7'h41};
      7'd50: r = {11'd1560, N_, 7'h3C, 7'h74};  7'd51: r = {11'd1560, N_, 7'h3D, 7'h74};
      7'd52: r = {11'd1560, N_, 7'h3E, 7'h74};  7'd53: r = {11'd1560, N_, 7'h3F, 7'h74};
      7'd54: r = {11'd1680, F_, 7'h30, 7'h40};  7'd55: r = {11'd1680, F_, 7'h32, 7'h40};
      7'd56: r = {11'd1680, F_, 7'h3C, 7'h40};  7'd57: r = {11'd1680, F_, 7'h3D, 7'h40};
      7'd58: r = {11'd1680, F_, 7'h3E, 7'h40};  7'd59: r = {11'd1680, F_, 7'h3F, 7'h40};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic rom_item_t rom_read(input logic [1:0] psel, input logic [ROM_IW-1:0] i);
    rom_item_t r;
    case (psel)
      PAT_PIANO:  r = rom_piano(i);
      PAT_GUITAR: r = rom_guitar(i);
      PAT_SYNTH:  r = rom_synth(i);
      default:    r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> src/csq_if.sv
// Channel interfaces of the chord pattern sequencer: input, result and configuration.
interface csq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [6:0]  note;
  logic [6:0]  velocity;
  logic [3:0]  channel;
  logic [10:0] bar_pos;
  logic        full_beat;
  modport source (output valid, action, note, velocity, channel, bar_pos, full_beat,
                  input ready);
  modport sink (input valid, action, note, velocity, channel, bar_pos, full_beat,
                output ready);
endinterface

interface csq_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] out_note;
  logic [6:0] out_velocity;
  logic [3:0] out_channel;
  logic       last;
  modport source (output valid, kind, out_note, out_velocity, out_channel, last, input ready);
  modport sink (input valid, kind, out_note, out_velocity, out_channel, last, output ready);
endinterface

interface csq_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> src/chord_pattern_sequencer.sv
// Top level of the chord pattern sequencer.
//
// in_ch carries note events and ticks; one beat is one item. Channel 0 note
// events edit the held chord, other channels pass through as a single result.
// A tick may refresh the chord, refill the 12 note slots and play the items of
// the selected pattern that fall since the previous tick. out_ch carries the
// results, with last set on the final result of an item; an item with no
// result gives none. cfg_ch writes the pattern select, always ready.
// The front queues up to two items while the back end works, so input is taken
// while a result waits. The back end handles one item at a time: a channel 0
// note off sweeps the held list; a tick may fill and copy the slots, then scan
// the pattern items (two passes at the bar wrap) with a list sweep after each
// pattern note off; at a full beat with an empty chord it flushes the sounding
// notes instead. The first result moves from the pending register to the
// output register when the second is found, or at the end.
// A stalled receiver holds the output register and the back end waits on it.
// Reset clears the lists, slots, position and pattern select; no clearing pass.
module chord_pattern_sequencer (
  input  logic      clk,
  input  logic      rst_n,
  csq_in_if.sink    in_ch,
  csq_out_if.source out_ch,
  csq_cfg_if.sink   cfg_ch
);
  import csq_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  csq_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  csq_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .cfg_ch  (cfg_ch),
    .out_ch  (out_ch)
  );
endmodule

>>> src/csq_front.sv
// Front end: accepts input beats, classifies them and queues them for the back end.
module csq_front (
  input  logic           clk,
  input  logic           rst_n,
  csq_in_if.sink         in_ch,
  output logic           q_valid,
  output csq_pkg::item_t q_item,
  input  logic           q_pop
);
  import csq_pkg::*;

  item_t      q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  item_t      cls;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  // An unknown action is taken and dropped here.
  assign push    = in_ch.valid && in_ch.ready && (in_ch.action != 2'd3);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = q_r[rp_r];

  always_comb begin
    cls.act_off = (in_ch.action == ACT_OFF);
    cls.note    = in_ch.note;
    cls.vel     = in_ch.velocity;
    cls.ch      = in_ch.channel;
    cls.full    = in_ch.full_beat;
    cls.now     = (in_ch.bar_pos >= BAR_LEN) ? in_ch.bar_pos - BAR_LEN
                                             : in_ch.bar_pos;
    if (in_ch.action == ACT_TICK) begin
      cls.ev = EV_TICK;
    end else if (in_ch.channel != 4'd0) begin
      cls.ev = EV_PASS;
    end else if (in_ch.action == ACT_ON) begin
      cls.ev = EV_HELD_ON;
    end else begin
      cls.ev = EV_HELD_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cls;
  end
endmodule

>>> src/csq_sort.sv
// Insertion sorter that keeps the lowest values seen since the last clear, in order.
module csq_sort (
  input  logic                     clk,
  input  logic                     clr,
  input  logic                     ins,
  input  logic [csq_pkg::VAL_W-1:0] val,
  output logic [csq_pkg::VAL_W-1:0] vals [csq_pkg::SLOT_COUNT]
);
  import csq_pkg::*;

  logic [VAL_W-1:0] e_r   [SLOT_COUNT];
  logic [VAL_W-1:0] e_nxt [SLOT_COUNT];

  assign vals = e_r;

  // The new value lands after any equal entries; the largest entry falls off.
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (e_r[i] <= val) begin
        e_nxt[i] = e_r[i];
      end else if (i == 0) begin
        e_nxt[i] = val;
      end else if (e_r[(i == 0) ? 0 : i-1] <= val) begin
        e_nxt[i] = val;
      end else begin
        e_nxt[i] = e_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (clr) begin
        e_r[i] <= '1;
      end else if (ins) begin
        e_r[i] <= e_nxt[i];
      end
    end
  end
endmodule

>>> src/csq_back.sv
// Back end: note lists, slot fill, pattern scan and the result register.
module csq_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  csq_pkg::item_t q_item,
  output logic           q_pop,
  csq_cfg_if.sink        cfg_ch,
  csq_out_if.source      out_ch
);
  import csq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PASS, S_HREM, S_FILL, S_SLOTS, S_FLUSH, S_PLAYCHK, S_SCAN, S_SREM, S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  item_t            cur_r, cur_nxt;
  logic [1:0]       psel_r;
  logic [6:0]       held_r [MAX_HELD];
  logic [6:0]       held_nxt [MAX_HELD];
  logic [HELD_CW-1:0] held_cnt_r, held_cnt_nxt;
  logic [6:0]       snap_r [MAX_HELD];
  logic [6:0]       snap_nxt [MAX_HELD];
  logic [HELD_CW-1:0] snap_cnt_r, snap_cnt_nxt;
  logic [7:0]       slots_r [SLOT_COUNT];
  logic [7:0]       slots_nxt [SLOT_COUNT];
  logic [7:0]       snd_r [MAX_SOUNDING];
  logic [7:0]       snd_nxt [MAX_SOUNDING];
  logic [SND_CW-1:0] snd_cnt_r, snd_cnt_nxt;
  logic [10:0]      prev_r, prev_nxt;

  logic [HELD_CW-1:0] hi_r, hi_nxt, hk_r, hk_nxt;
  logic [SND_CW-1:0]  si_r, si_nxt, sk_r, sk_nxt;
  logic [HELD_IW-1:0] gi_r, gi_nxt;
  logic [VAL_W-1:0]   goff_r, goff_nxt;
  logic [GEN_CW-1:0]  gcnt_r, gcnt_nxt;
  logic [ROM_IW-1:0]  j_r, j_nxt;
  logic               phase_r, phase_nxt;
  logic [7:0]         tgt_r, tgt_nxt;
  logic [RES_CW-1:0]  res_n_r, res_n_nxt;
  res_t               pend_r, pend_nxt, out_r, out_nxt;
  logic               pend_v_r, pend_v_nxt, out_v_r, out_v_nxt;

  logic               sort_clr, sort_ins;
  logic [VAL_W-1:0]   sort_val;
  logic [VAL_W-1:0]   sorted [SLOT_COUNT];

  rom_item_t          rom_e;
  logic [ROM_IW-1:0]  rom_n;
  logic [14:0]        prod;
  logic [3:0]         oct;
  logic [6:0]         oct12;
  logic [SLOT_IW-1:0] rem;
  logic [7:0]         nn;
  logic [10:0]        hi_t;
  logic               in_win;
  logic               out_free, out_load, emit_req, emit_go;
  res_t               emit_res;

  csq_sort u_sort (
    .clk  (clk),
    .clr  (sort_clr),
    .ins  (sort_ins),
    .val  (sort_val),
    .vals (sorted)
  );

  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_v_r;
  assign out_ch.kind         = out_r.kind;
  assign out_ch.out_note     = out_r.note;
  assign out_ch.out_velocity = out_r.vel;
  assign out_ch.out_channel  = out_r.ch;
  assign out_ch.last         = out_r.last;

  // Pattern item to note: slot[d1 mod 12] shifted by whole octaves around d1 = 60.
  always_comb begin
    rom_e  = rom_read(psel_r, j_r);
    rom_n  = rom_len(psel_r);
    prod   = 15'(rom_e.d1) * 15'd171;
    oct    = prod[14:11];
    oct12  = 7'({oct, 3'b000}) + 7'({oct, 2'b00});
    rem    = SLOT_IW'(rom_e.d1 - oct12);
    nn     = slots_r[rem] + {1'b0, oct12} - 8'd60;
    hi_t   = (cur_r.now == 11'd0) ? BAR_LEN : cur_r.now;
    in_win = phase_r ? (rom_e.t == 11'd0) : ((prev_r < rom_e.t) && (rom_e.t <= hi_t));
  end

  assign out_free = !out_v_r || out_ch.ready;
  assign emit_go  = (res_n_r >= RES_CW'(RES_MAX)) || !pend_v_r || out_free;

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    held_nxt     = held_r;
    held_cnt_nxt = held_cnt_r;
    snap_nxt     = snap_r;
    snap_cnt_nxt = snap_cnt_r;
    slots_nxt    = slots_r;
    snd_nxt      = snd_r;
    snd_cnt_nxt  = snd_cnt_r;
    prev_nxt     = prev_r;
    hi_nxt       = hi_r;
    hk_nxt       = hk_r;
    si_nxt       = si_r;
    sk_nxt       = sk_r;
    gi_nxt       = gi_r;
    goff_nxt     = goff_r;
    gcnt_nxt     = gcnt_r;
    j_nxt        = j_r;
    phase_nxt    = phase_r;
    tgt_nxt      = tgt_r;
    res_n_nxt    = res_n_r;
    pend_nxt     = pend_r;
    pend_v_nxt   = pend_v_r;
    out_nxt      = out_r;
    out_load     = 1'b0;
    q_pop        = 1'b0;
    sort_clr     = 1'b0;
    sort_ins     = 1'b0;
    sort_val     = '0;
    emit_req     = 1'b0;
    emit_res     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cur_nxt   = q_item;
          res_n_nxt = '0;
          case (q_item.ev)
            EV_PASS: state_nxt = S_PASS;
            EV_HELD_ON: begin
              if (held_cnt_r < HELD_CW'(MAX_HELD)) begin
                held_nxt[held_cnt_r[HELD_IW-1:0]] = q_item.note;
                held_cnt_nxt = held_cnt_r + 1'b1;
              end
              state_nxt = S_DONE;
            end
            EV_HELD_OFF: begin
              hi_nxt    = '0;
              hk_nxt    = '0;
              state_nxt = S_HREM;
            end
            default: begin
              state_nxt = S_PLAYCHK;
              if (q_item.full || (snd_cnt_r == '0 && held_cnt_r != '0)) begin
                snap_nxt     = held_r;
                snap_cnt_nxt = held_cnt_r;
                if (held_cnt_r != '0) begin
                  sort_clr  = 1'b1;
                  gi_nxt    = '0;
                  goff_nxt  = '0;
                  gcnt_nxt  = '0;
                  state_nxt = S_FILL;
                end else if (snd_cnt_r != '0) begin
                  si_nxt    = '0;
                  state_nxt = S_FLUSH;
                end
              end
            end
          endcase
        end
      end
      S_PASS: begin
        emit_req = 1'b1;
        emit_res = '{kind: cur_r.act_off, note: {1'b0, cur_r.note}, vel: cur_r.vel,
                     ch: cur_r.ch, last: 1'b0};
        if (emit_go) state_nxt = S_DONE;
      end
      S_HREM: begin
        if (hi_r == held_cnt_r) begin
          held_cnt_nxt = hk_r;
          state_nxt    = S_DONE;
        end else begin
          if (held_r[hi_r[HELD_IW-1:0]] != cur_r.note) begin
            held_nxt[hk_r[HELD_IW-1:0]] = held_r[hi_r[HELD_IW-1:0]];
            hk_nxt = hk_r + 1'b1;
          end
          hi_nxt = hi_r + 1'b1;
        end
      end
      S_FILL: begin
        // Stack the chord upward an octave per pass until enough values exist.
        sort_ins = 1'b1;
        sort_val = VAL_W'(snap_r[gi_r]) + goff_r;
        gcnt_nxt = gcnt_r + 1'b1;
        if (HELD_CW'(gi_r) + 1'b1 == snap_cnt_r) begin
          gi_nxt   = '0;
          goff_nxt = goff_r + VAL_W'(12);
          if (gcnt_r + 1'b1 >= GEN_CW'(SLOT_COUNT)) state_nxt = S_SLOTS;
        end else begin
          gi_nxt = gi_r + 1'b1;
        end
      end
      S_SLOTS: begin
        for (int s = 0; s < SLOT_COUNT; s++) slots_nxt[s] = sorted[s][7:0];
        state_nxt = S_PLAYCHK;
      end
      S_FLUSH: begin
        if (si_r == snd_cnt_r) begin
          snd_cnt_nxt = '0;
          state_nxt   = S_PLAYCHK;
        end else begin
          emit_req = 1'b1;
          emit_res = '{kind: KIND_OFF, note: snd_r[si_r[SND_IW-1:0]], vel: 7'd0,
                       ch: 4'd0, last: 1'b0};
          if (emit_go) si_nxt = si_r + 1'b1;
        end
      end
      S_PLAYCHK: begin
        j_nxt = '0;
        phase_nxt = (cur_r.now == 11'd0) && (prev_r == 11'd0);
        state_nxt = (snap_cnt_r == '0) ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        // The first pass covers (previous, now], or (previous, bar end] at the wrap;
        // the second pass plays the items at time zero after a wrap.
        if (j_r >= rom_n) begin
          if (!phase_r && cur_r.now == 11'd0) begin
            phase_nxt = 1'b1;
            j_nxt     = '0;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (in_win) begin
          emit_req = 1'b1;
          emit_res = '{kind: rom_e.off, note: nn, vel: rom_e.d2, ch: 4'd0, last: 1'b0};
          if (emit_go) begin
            j_nxt = j_r + 1'b1;
            if (rom_e.off == KIND_ON) begin
              if (snd_cnt_r < SND_CW'(MAX_SOUNDING)) begin
                snd_nxt[snd_cnt_r[SND_IW-1:0]] = nn;
                snd_cnt_nxt = snd_cnt_r + 1'b1;
              end
            end else begin
              tgt_nxt   = nn;
              si_nxt    = '0;
              sk_nxt    = '0;
              state_nxt = S_SREM;
            end
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_SREM: begin
        if (si_r == snd_cnt_r) begin
          snd_cnt_nxt = sk_r;
          state_nxt   = S_SCAN;
        end else begin
          if (snd_r[si_r[SND_IW-1:0]] != tgt_r) begin
            snd_nxt[sk_r[SND_IW-1:0]] = snd_r[si_r[SND_IW-1:0]];
            sk_nxt = sk_r + 1'b1;
          end
          si_nxt = si_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_nxt      = pend_r;
            out_nxt.last = 1'b1;
            out_load     = 1'b1;
            pend_v_nxt   = 1'b0;
          end
          if (cur_r.ev == EV_TICK) prev_nxt = cur_r.now;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // A new result parks in the pending stage until the next one shows whether it is last.
    if (emit_req && emit_go && res_n_r < RES_CW'(RES_MAX)) begin
      res_n_nxt = res_n_r + 1'b1;
      if (pend_v_r) begin
        out_nxt  = pend_r;
        out_load = 1'b1;
      end
      pend_nxt   = emit_res;
      pend_v_nxt = 1'b1;
    end

    out_v_nxt = out_load || (out_v_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      psel_r     <= PAT_PIANO;
      held_cnt_r <= '0;
      snap_cnt_r <= '0;
      snd_cnt_r  <= '0;
      prev_r     <= '0;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
      for (int s = 0; s < SLOT_COUNT; s++) slots_r[s] <= '0;
    end else begin
      state_r    <= state_nxt;
      if (cfg_ch.valid) psel_r <= cfg_ch.data;
      held_cnt_r <= held_cnt_nxt;
      snap_cnt_r <= snap_cnt_nxt;
      snd_cnt_r  <= snd_cnt_nxt;
      prev_r     <= prev_nxt;
      pend_v_r   <= pend_v_nxt;
      out_v_r    <= out_v_nxt;
      slots_r    <= slots_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    held_r  <= held_nxt;
    snap_r  <= snap_nxt;
    snd_r   <= snd_nxt;
    hi_r    <= hi_nxt;
    hk_r    <= hk_nxt;
    si_r    <= si_nxt;
    sk_r    <= sk_nxt;
    gi_r    <= gi_nxt;
    goff_r  <= goff_nxt;
    gcnt_r  <= gcnt_nxt;
    j_r     <= j_nxt;
    phase_r <= phase_nxt;
    tgt_r   <= tgt_nxt;
    res_n_r <= res_n_nxt;
    pend_r  <= pend_nxt;
    out_r   <= out_nxt;
  end
endmodule
